// ===== src/mrpa_pkg.sv =====
`default_nettype none
package mrpa_pkg;

  localparam int ENTRIES    = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAGE_LSB   = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 56;
  localparam int CNT_W      = 5;
  localparam int SEL_W      = 4;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CUT    = 2'd1,
    OP_PAGE   = 2'd2,
    OP_LOWEST = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_TAKE,
    ST_CUT_SUM,
    ST_CUT_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic advance;
    logic take;
    logic cut_sum;
    logic cut_apply;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic rem_zero;
    logic rem_last;
    logic fit;
    logic cut_rev;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/mrpa_ctrl.sv =====
`default_nettype none
module mrpa_ctrl
  import mrpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          OP_LOAD: begin
            cmd.load  = 1'b1;
            state_nxt = ST_FINISH;
          end
          OP_CUT: begin
            if (sts.cut_rev || sts.rem_zero) begin
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_CUT_SUM;
            end
          end
          default: begin
            state_nxt = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.rem_zero) begin
          state_nxt = ST_FINISH;
        end else if (sts.fit) begin
          state_nxt = ST_TAKE;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_CUT_SUM: begin
        cmd.cut_sum = 1'b1;
        state_nxt   = ST_CUT_APPLY;
      end
      ST_CUT_APPLY: begin
        cmd.cut_apply = 1'b1;
        cmd.advance   = 1'b1;
        state_nxt     = sts.rem_last ? ST_FINISH : ST_CUT_SUM;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/mrpa_datapath.sv =====
`default_nettype none
module mrpa_datapath
  import mrpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [SEL_W-1:0]  in_entry_index,
  input  wire logic [ADDR_W-1:0] in_load_base,
  input  wire logic [ADDR_W-1:0] in_load_length,
  input  wire logic              in_load_available,
  input  wire logic [ADDR_W-1:0] in_cut_start,
  input  wire logic [ADDR_W-1:0] in_cut_end,
  input  wire logic [ADDR_W-1:0] in_alloc_size,
  output logic [ADDR_W-1:0]      out_alloc_address,
  output logic                   out_alloc_found,
  input  wire cmd_t              cmd,
  output sts_t                   sts
);

  logic [ADDR_W-1:0] base_mem [ENTRIES];
  logic [ADDR_W-1:0] len_mem  [ENTRIES];
  logic              use_mem  [ENTRIES];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  used;
  op_t               op_r;
  logic [SEL_W-1:0]  idx_r;
  logic [ADDR_W-1:0] lbase_r, llen_r, cstart_r, cend_r, amount_r;
  logic              lavail_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [CNT_W-1:0]  rem_r;
  logic [ADDR_W-1:0] cb_r;
  logic [ADDR_W:0]   rend_r;
  logic [ADDR_W-1:0] addr_r, out_addr_r;
  logic              found_r, out_found_r;

  logic [ADDR_W-1:0] rd_base, rd_len;
  logic              rd_use;
  logic              cut_hit;

  assign used = (count_r > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : count_r;

  assign rd_base = base_mem[ptr_r];
  assign rd_len  = len_mem[ptr_r];
  assign rd_use  = use_mem[ptr_r];
  assign cut_hit = (cstart_r >= cb_r) && ({1'b0, cend_r} <= rend_r);

  assign sts.op       = op_r;
  assign sts.rem_zero = (rem_r == '0);
  assign sts.rem_last = (rem_r == CNT_W'(1));
  assign sts.cut_rev  = (cend_r < cstart_r);
  assign sts.fit      = rd_use && (rd_base[PAGE_LSB-1:0] == '0) && (rd_len >= amount_r);

  assign out_alloc_address = out_addr_r;
  assign out_alloc_found   = out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(in_opcode);
      idx_r    <= in_entry_index;
      lbase_r  <= in_load_base;
      llen_r   <= in_load_length;
      lavail_r <= in_load_available;
      cstart_r <= in_cut_start;
      cend_r   <= in_cut_end;
      amount_r <= (op_t'(in_opcode) == OP_PAGE) ? ADDR_W'(PAGE_BYTES) : in_alloc_size;
      rem_r    <= used;
      ptr_r    <= (op_t'(in_opcode) == OP_PAGE) ? IDX_W'(used - CNT_W'(1)) : '0;
      addr_r   <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.advance) begin
        rem_r <= rem_r - CNT_W'(1);
        ptr_r <= (op_r == OP_PAGE) ? ptr_r - IDX_W'(1) : ptr_r + IDX_W'(1);
      end
      if (cmd.take) begin
        addr_r  <= rd_base;
        found_r <= 1'b1;
      end
      if (cmd.cut_sum) begin
        cb_r   <= rd_base;
        rend_r <= {1'b0, rd_base} + {1'b0, rd_len};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (32'(idx_r) < ENTRIES) begin
        base_mem[IDX_W'(idx_r)] <= lbase_r;
        len_mem[IDX_W'(idx_r)]  <= llen_r;
        use_mem[IDX_W'(idx_r)]  <= lavail_r;
      end
    end else if (cmd.take) begin
      base_mem[ptr_r] <= rd_base + amount_r;
      len_mem[ptr_r]  <= rd_len - amount_r;
    end else if (cmd.cut_apply && cut_hit) begin
      base_mem[ptr_r] <= cend_r;
      len_mem[ptr_r]  <= ADDR_W'(rend_r - {1'b0, cend_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_addr_r  <= addr_r;
      out_found_r <= found_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/memory_region_page_allocator_unit.sv =====
// Load writes the addressed table entry and then finishes; allocations scan the table,
// one table entry examined per cycle; cut takes a sum and an apply state per entry,
// and a reversed range or an entry count of zero skips straight to the finish state.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset (rst_n, synchronous) clears the controller, the output valid and entry_count.
// The region table is not cleared and holds unknown data until an entry is loaded.
`default_nettype none
module memory_region_page_allocator_unit
  import mrpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [SEL_W-1:0]  in_entry_index,
  input  wire logic [ADDR_W-1:0] in_load_base,
  input  wire logic [ADDR_W-1:0] in_load_length,
  input  wire logic              in_load_available,
  input  wire logic [ADDR_W-1:0] in_cut_start,
  input  wire logic [ADDR_W-1:0] in_cut_end,
  input  wire logic [ADDR_W-1:0] in_alloc_size,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_alloc_address,
  output logic                   out_alloc_found
);

  cmd_t ctl_cmd;
  sts_t dp_sts;

  mrpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  mrpa_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_load_base      (in_load_base),
    .in_load_length    (in_load_length),
    .in_load_available (in_load_available),
    .in_cut_start      (in_cut_start),
    .in_cut_end        (in_cut_end),
    .in_alloc_size     (in_alloc_size),
    .out_alloc_address (out_alloc_address),
    .out_alloc_found   (out_alloc_found),
    .cmd               (ctl_cmd),
    .sts               (dp_sts)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while a previous word is still in progress");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.emit |-> !out_valid || !out_stall)
    else $error("result overwrote a word that was not yet taken");

  a_fail_address_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_alloc_found |-> out_alloc_address == '0)
    else $error("result without a found flag carries a nonzero address");

  a_one_command_to_table: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({ctl_cmd.load, ctl_cmd.take, ctl_cmd.cut_apply}) <= 1)
    else $error("more than one table update issued in a cycle");

endmodule
`default_nettype wire

// ===== dv/memory_region_page_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
module memory_region_page_allocator_unit_tb
  import mrpa_pkg::*;
();

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [ADDR_W-1:0] PAGE_AMOUNT = ADDR_W'(PAGE_BYTES);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;

  typedef struct {
    op_t               opcode;
    logic [SEL_W-1:0]  entry_index;
    logic [ADDR_W-1:0] load_base;
    logic [ADDR_W-1:0] load_length;
    logic              load_available;
    logic [ADDR_W-1:0] cut_start;
    logic [ADDR_W-1:0] cut_end;
    logic [ADDR_W-1:0] alloc_size;
  } region_cmd_t;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic              found;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_opcode = '0;
  logic [SEL_W-1:0]  in_entry_index = '0;
  logic [ADDR_W-1:0] in_load_base = '0;
  logic [ADDR_W-1:0] in_load_length = '0;
  logic              in_load_available = 1'b0;
  logic [ADDR_W-1:0] in_cut_start = '0;
  logic [ADDR_W-1:0] in_cut_end = '0;
  logic [ADDR_W-1:0] in_alloc_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_alloc_address;
  logic              out_alloc_found;

  logic [ADDR_W-1:0] tbl_base [ENTRIES];
  logic [ADDR_W-1:0] tbl_len [ENTRIES];
  logic              tbl_usable [ENTRIES];
  int                tbl_count = 0;

  region_cmd_t region_cmd_q[$];
  grant_t      grant_q[$];
  region_cmd_t held_cmd;
  int          results_owed = 0;
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          stall_run = 0;
  int          cycle_count = 0;
  bit          steady_tail = 1'b0;

  memory_region_page_allocator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_load_base     (in_load_base),
    .in_load_length   (in_load_length),
    .in_load_available(in_load_available),
    .in_cut_start     (in_cut_start),
    .in_cut_end       (in_cut_end),
    .in_alloc_size    (in_alloc_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_alloc_address(out_alloc_address),
    .out_alloc_found  (out_alloc_found)
  );

  always #10 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] rand_aligned();
    logic [ADDR_W-1:0] r;
    r = rand_addr();
    return {r[ADDR_W-1:PAGE_LSB], {PAGE_LSB{1'b0}}};
  endfunction

  function automatic logic [ADDR_W-1:0] rand_pages(input int lo, input int hi);
    return ADDR_W'($urandom_range(lo, hi)) << PAGE_LSB;
  endfunction

  function automatic grant_t claim_region(input int i, input logic [ADDR_W-1:0] amount);
    grant_t g;
    g.address = tbl_base[i];
    g.found = 1'b1;
    tbl_base[i] = tbl_base[i] + amount;
    tbl_len[i] = tbl_len[i] - amount;
    return g;
  endfunction

  function automatic bit region_fits(input int i, input logic [ADDR_W-1:0] amount);
    return tbl_usable[i] && tbl_base[i][PAGE_LSB-1:0] == '0 && tbl_len[i] >= amount;
  endfunction

  function automatic grant_t predict_grant(input region_cmd_t c);
    grant_t g;
    int used;
    logic [ADDR_W:0] span_end;
    g.address = '0;
    g.found = 1'b0;
    used = (tbl_count > ENTRIES) ? ENTRIES : tbl_count;
    case (c.opcode)
      OP_LOAD: begin
        tbl_base[c.entry_index] = c.load_base;
        tbl_len[c.entry_index] = c.load_length;
        tbl_usable[c.entry_index] = c.load_available;
      end
      OP_CUT: begin
        if (c.cut_end >= c.cut_start) begin
          for (int i = 0; i < used; i++) begin
            span_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
            if (c.cut_start >= tbl_base[i] && {1'b0, c.cut_end} <= span_end) begin
              tbl_base[i] = c.cut_end;
              tbl_len[i] = span_end[ADDR_W-1:0] - c.cut_end;
            end
          end
        end
      end
      OP_PAGE: begin
        for (int i = used - 1; i >= 0 && !g.found; i--) begin
          if (region_fits(i, PAGE_AMOUNT)) g = claim_region(i, PAGE_AMOUNT);
        end
      end
      default: begin
        for (int i = 0; i < used && !g.found; i++) begin
          if (region_fits(i, c.alloc_size)) g = claim_region(i, c.alloc_size);
        end
      end
    endcase
    return g;
  endfunction

  function automatic region_cmd_t make_cmd(input op_t op, input int idx,
                                           input logic [ADDR_W-1:0] base,
                                           input logic [ADDR_W-1:0] len, input bit avail,
                                           input logic [ADDR_W-1:0] cstart,
                                           input logic [ADDR_W-1:0] cend,
                                           input logic [ADDR_W-1:0] size);
    region_cmd_t c;
    c.opcode = op;
    c.entry_index = SEL_W'(idx);
    c.load_base = base;
    c.load_length = len;
    c.load_available = avail;
    c.cut_start = cstart;
    c.cut_end = cend;
    c.alloc_size = size;
    return c;
  endfunction

  function automatic region_cmd_t random_region_cmd();
    region_cmd_t c;
    int pick;
    int i;
    logic [ADDR_W:0] span_end;
    logic [ADDR_W:0] lo;
    logic [ADDR_W:0] hi;
    logic [ADDR_W-1:0] swap;
    c = make_cmd(OP_LOAD, $urandom_range(0, ENTRIES - 1), rand_addr(), rand_addr(),
                 $urandom_range(0, 1), rand_addr(), rand_addr(), rand_addr());
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      c.opcode = OP_LOAD;
      case ($urandom_range(0, 9))
        0: c.load_base = rand_addr();
        1: c.load_base = ADDR_MAX - rand_pages(0, 8) - ADDR_W'(PAGE_BYTES - 1);
        default: c.load_base = rand_aligned();
      endcase
      case ($urandom_range(0, 9))
        0: c.load_length = rand_addr();
        1: c.load_length = ADDR_MAX;
        2: c.load_length = '0;
        default: c.load_length = rand_pages(1, 256);
      endcase
      c.load_available = ($urandom_range(0, 4) != 0);
    end else if (pick < 40) begin
      c.opcode = OP_CUT;
      if ($urandom_range(0, 9) < 7) begin
        i = $urandom_range(0, ENTRIES - 1);
        span_end = {1'b0, tbl_base[i]} + {1'b0, tbl_len[i]};
        lo = {1'b0, tbl_base[i]} + {1'b0, rand_pages(0, 4)};
        if (lo > span_end) lo = {1'b0, tbl_base[i]};
        hi = lo + {1'b0, rand_pages(0, 3)};
        if (hi > span_end || hi[ADDR_W]) hi = lo;
        c.cut_start = lo[ADDR_W-1:0];
        c.cut_end = hi[ADDR_W-1:0];
        if ($urandom_range(0, 9) == 0) begin
          swap = c.cut_start;
          c.cut_start = c.cut_end;
          c.cut_end = swap;
        end
      end
    end else if (pick < 72) begin
      c.opcode = OP_PAGE;
    end else begin
      c.opcode = OP_LOWEST;
      case ($urandom_range(0, 11))
        0: c.alloc_size = '0;
        1: c.alloc_size = ADDR_MAX;
        2: c.alloc_size = rand_addr();
        3: c.alloc_size = rand_addr() >> $urandom_range(8, 50);
        default: c.alloc_size = rand_pages(1, 16);
      endcase
    end
    return c;
  endfunction

  task automatic wait_table_idle();
    while (region_cmd_q.size() != 0 || results_owed != 0) @(posedge clk);
  endtask

  task automatic set_entry_count(input int value);
    wait_table_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    tbl_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_random(input int count, input int n_items);
    set_entry_count(count);
    repeat (n_items) region_cmd_q.push_back(random_region_cmd());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        grant_q.push_back(predict_grant(held_cmd));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!steady_tail && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (region_cmd_q.size() != 0) begin
          held_cmd = region_cmd_q.pop_front();
          results_owed++;
          in_opcode <= held_cmd.opcode;
          in_entry_index <= held_cmd.entry_index;
          in_load_base <= held_cmd.load_base;
          in_load_length <= held_cmd.load_length;
          in_load_available <= held_cmd.load_available;
          in_cut_start <= held_cmd.cut_start;
          in_cut_end <= held_cmd.cut_end;
          in_alloc_size <= held_cmd.alloc_size;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          $error("unexpected result word: alloc_address %h alloc_found %b",
                 out_alloc_address, out_alloc_found);
          mismatch_count++;
        end else begin
          want = grant_q.pop_front();
          results_owed--;
          if (out_alloc_address !== want.address) begin
            $error("alloc_address: expected %h, got %h", want.address, out_alloc_address);
            mismatch_count++;
          end
          if (out_alloc_found !== want.found) begin
            $error("alloc_found: expected %b, got %b", want.found, out_alloc_found);
            mismatch_count++;
          end
        end
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (!steady_tail && $urandom_range(0, 11) == 0) begin
        stall_run = $urandom_range(0, 12);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_base[i] = '0;
      tbl_len[i] = '0;
      tbl_usable[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Every entry is loaded before any scan can read it.
    set_entry_count(0);
    region_cmd_q.push_back(make_cmd(OP_LOAD, 0, '0, 56'h3000, 1'b1, '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOAD, 1, 56'h1000_0000, 56'h10_0000, 1'b1,
                                    '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOAD, 2, 56'h1234, 56'h100_0000, 1'b1,
                                    '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOAD, 3, 56'h2000_0000, ADDR_MAX, 1'b0,
                                    '0, '0, '0));
    for (int i = 4; i < ENTRIES - 2; i++) begin
      region_cmd_q.push_back(make_cmd(OP_LOAD, i, ADDR_W'(i) << 28, rand_pages(1, 8),
                                      (i % 3) != 0, '0, '0, '0));
    end
    region_cmd_q.push_back(make_cmd(OP_LOAD, ENTRIES - 2, ADDR_MAX, ADDR_MAX, 1'b0,
                                    ADDR_MAX, ADDR_MAX, ADDR_MAX));
    // The top page of the address space makes the bumped base wrap to zero.
    region_cmd_q.push_back(make_cmd(OP_LOAD, ENTRIES - 1, 56'hFF_FFFF_FFFF_F000, 56'h2000,
                                    1'b1, '0, '0, '0));

    set_entry_count(ENTRIES);
    region_cmd_q.push_back(make_cmd(OP_PAGE, 0, '0, '0, 1'b0, '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_PAGE, 0, '0, '0, 1'b0, '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOWEST, 0, '0, '0, 1'b0, '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOWEST, 0, '0, '0, 1'b0, '0, '0, ADDR_MAX));
    region_cmd_q.push_back(make_cmd(OP_CUT, 0, '0, '0, 1'b0, 56'h1000_5000, 56'h1000_1000,
                                    '0));
    region_cmd_q.push_back(make_cmd(OP_CUT, 0, '0, '0, 1'b0, 56'h1000_1000, 56'h1000_2000,
                                    '0));
    region_cmd_q.push_back(make_cmd(OP_CUT, 0, '0, '0, 1'b0, '0, ADDR_MAX, '0));
    region_cmd_q.push_back(make_cmd(OP_CUT, 0, '0, '0, 1'b0, '0, '0, '0));
    region_cmd_q.push_back(make_cmd(OP_LOWEST, 0, '0, '0, 1'b0, '0, '0, PAGE_AMOUNT));

    fill_random(ENTRIES, 600);
    fill_random(31, 300);
    fill_random(0, 20);
    fill_random(1, 100);
    repeat (4) fill_random($urandom_range(2, ENTRIES), 150);
    steady_tail = 1'b1;
    fill_random(ENTRIES, 200);

    wait_table_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d expected result words never arrived", grant_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
